/* rtl/core/quartile_summary_unsigned_core_macros.svh */
// ----------------------------------------------------------------------------
// quartile summary assertion macros
// shared concurrent assertion forms for the quartile summary core
// ----------------------------------------------------------------------------
`ifndef QUARTILE_SUMMARY_UNSIGNED_CORE_MACROS_SVH
`define QUARTILE_SUMMARY_UNSIGNED_CORE_MACROS_SVH

// same-cycle implication
`define QSU_ASSERT_IMPLY(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("qsu assertion failed");

// next-cycle implication
`define QSU_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("qsu assertion failed");

`endif

/* rtl/core/qsu_pkg.sv */
// ----------------------------------------------------------------------------
// qsu_pkg
// types and constants of the quartile summary core
// ----------------------------------------------------------------------------
package qsu_pkg;

   localparam int SAMPLE_W   = 32;
   localparam int SUM_W      = 42;
   localparam int MEAN_W     = 40;
   localparam int COUNT_W    = 11;
   localparam int FRAC_W     = 8;
   localparam int DIVIDEND_W = SUM_W + FRAC_W;

   localparam logic [2:0] PICK_MIN    = 3'd0;
   localparam logic [2:0] PICK_LOWER  = 3'd1;
   localparam logic [2:0] PICK_MEDIAN = 3'd2;
   localparam logic [2:0] PICK_UPPER  = 3'd3;
   localparam logic [2:0] PICK_MAX    = 3'd4;

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
      logic                has_sample;
      logic                last;
   } req_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] minimum;
      logic [SAMPLE_W-1:0] lower_quartile;
      logic [SAMPLE_W-1:0] median;
      logic [SAMPLE_W-1:0] upper_quartile;
      logic [SAMPLE_W-1:0] maximum;
      logic [SUM_W-1:0]    sum_total;
      logic [MEAN_W-1:0]   mean_fixed;
      logic [COUNT_W-1:0]  count;
      logic                overflowed;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PASS,
      ST_MERGE,
      ST_FETCH,
      ST_WAIT,
      ST_EMIT,
      ST_PICK_RD,
      ST_PICK_CAP,
      ST_DIVIDE,
      ST_DONE
   } state_type;

endpackage

/* rtl/core/qsu_ram.sv */
// ----------------------------------------------------------------------------
// qsu_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module qsu_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/qsu_divider.sv */
// ----------------------------------------------------------------------------
// qsu_divider
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module qsu_divider #(
   parameter int DIVISOR_W = 11
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [qsu_pkg::DIVIDEND_W-1:0]    dividend,
   input  logic [DIVISOR_W-1:0]              divisor,
   output logic                              done,
   output logic [qsu_pkg::DIVIDEND_W-1:0]    quotient
);

   import qsu_pkg::*;

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  div_ff, div_in;
   logic [DIVISOR_W:0]    trial;
   logic                  ge;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      trial   = {rem_ff, quo_ff[DIVIDEND_W-1]};
      ge      = trial >= {1'b0, div_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         rem_in = ge ? DIVISOR_W'(trial - {1'b0, div_ff}) : trial[DIVISOR_W-1:0];
         quo_in = {quo_ff[DIVIDEND_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DIVIDEND_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

/* rtl/core/quartile_summary_unsigned_core.sv */
// ----------------------------------------------------------------------------
// quartile_summary_unsigned_core
// five-number summary, total and mean of a set of unsigned values
//
//   channel  ports                        payload
//   request  req_valid req_stall          req_data   (sample, has_sample, last)
//   response rsp_valid rsp_stall          rsp_data   (summary of one set)
//
// loading transactions are taken back to back while idle; requests stall from
// a closing transaction until its result enters the output register; the
// closing transaction runs a bottom-up merge sort between two rams over
// ceil(log2 n) passes, then order statistic reads and a division for the mean
// reset clears state, count, sum and flags; the value rams need no clearing
// the result waits in an output register while the next set loads
// ----------------------------------------------------------------------------
module quartile_summary_unsigned_core #(
   parameter int MAX_VALUES = 1024
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  qsu_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output qsu_pkg::rsp_type rsp_data
);

   import qsu_pkg::*;

   `include "quartile_summary_unsigned_core_macros.svh"

   localparam int AW = $clog2(MAX_VALUES);
   localparam int CW = $clog2(MAX_VALUES + 1);

   state_type          state_ff, state_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic               ovf_ff, ovf_in;
   logic [CW:0]        width_ff, width_in;
   logic [CW-1:0]      lo_ff, lo_in, mid_ff, mid_in, hi_ff, hi_in;
   logic [CW-1:0]      i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic [SAMPLE_W-1:0] a_ff, a_in, b_ff, b_in;
   logic               a_ok_ff, a_ok_in, b_ok_ff, b_ok_in;
   logic               src_ff, src_in, tgt_ff, tgt_in;
   logic [2:0]         pick_ff, pick_in;
   rsp_type            res_ff, res_in;
   rsp_type            rsp_data_ff, rsp_data_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic               req_acc, out_free, load_we, sort_we;
   logic [SAMPLE_W-1:0] sort_wdata, rd_data, rd0, rd1;
   logic [AW-1:0]      rd_addr;
   logic [CW+1:0]      lo_w, hi_w, n_w, n3;
   logic               div_start, div_done;
   logic [DIVIDEND_W-1:0] quotient;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      sum_in       = sum_ff;
      ovf_in       = ovf_ff;
      width_in     = width_ff;
      lo_in        = lo_ff;
      mid_in       = mid_ff;
      hi_in        = hi_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      a_ok_in      = a_ok_ff;
      b_ok_in      = b_ok_ff;
      src_in       = src_ff;
      tgt_in       = tgt_ff;
      pick_in      = pick_ff;
      res_in       = res_ff;
      load_we      = 1'b0;
      sort_we      = 1'b0;
      sort_wdata   = a_ff;
      rd_addr      = '0;
      div_start    = 1'b0;
      req_acc      = req_valid && !req_stall;
      out_free     = !rsp_valid_ff || !rsp_stall;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      n_w          = (CW + 2)'(count_ff);
      lo_w         = (CW + 2)'(lo_ff) + (CW + 2)'(width_ff);
      hi_w         = (CW + 2)'(lo_ff) + ((CW + 2)'(width_ff) << 1);
      n3           = (n_w << 1) + n_w;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               if (req_data.has_sample) begin
                  if (count_ff < CW'(MAX_VALUES)) begin
                     load_we  = 1'b1;
                     count_in = count_ff + 1'b1;
                     sum_in   = sum_ff + SUM_W'(req_data.sample);
                  end else begin
                     ovf_in = 1'b1;
                  end
               end
               if (req_data.last) begin
                  width_in = (CW + 1)'(1);
                  src_in   = 1'b0;
                  state_in = ST_PASS;
               end
            end
         end
         ST_PASS: begin
            if (width_ff >= (CW + 1)'(count_ff)) begin
               if (count_ff == '0) begin
                  res_in            = '0;
                  res_in.overflowed = ovf_ff;
                  state_in          = ST_DONE;
               end else begin
                  pick_in  = PICK_MIN;
                  state_in = ST_PICK_RD;
               end
            end else begin
               lo_in    = '0;
               state_in = ST_MERGE;
            end
         end
         ST_MERGE: begin
            if (lo_ff >= count_ff) begin
               width_in = width_ff << 1;
               src_in   = !src_ff;
               state_in = ST_PASS;
            end else begin
               mid_in   = (lo_w >= n_w) ? count_ff : lo_w[CW-1:0];
               hi_in    = (hi_w >= n_w) ? count_ff : hi_w[CW-1:0];
               i_in     = lo_ff;
               j_in     = mid_in;
               k_in     = lo_ff;
               a_ok_in  = 1'b0;
               b_ok_in  = 1'b0;
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            if (!a_ok_ff && i_ff < mid_ff) begin
               rd_addr  = i_ff[AW-1:0];
               i_in     = i_ff + 1'b1;
               tgt_in   = 1'b0;
               state_in = ST_WAIT;
            end else if (!b_ok_ff && j_ff < hi_ff) begin
               rd_addr  = j_ff[AW-1:0];
               j_in     = j_ff + 1'b1;
               tgt_in   = 1'b1;
               state_in = ST_WAIT;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_WAIT: begin
            if (tgt_ff) begin
               b_in    = rd_data;
               b_ok_in = 1'b1;
            end else begin
               a_in    = rd_data;
               a_ok_in = 1'b1;
            end
            state_in = ST_FETCH;
         end
         ST_EMIT: begin
            if (a_ok_ff || b_ok_ff) begin
               sort_we  = 1'b1;
               k_in     = k_ff + 1'b1;
               state_in = ST_FETCH;
               if (b_ok_ff && (!a_ok_ff || b_ff < a_ff)) begin
                  sort_wdata = b_ff;
                  b_ok_in    = 1'b0;
               end else begin
                  sort_wdata = a_ff;
                  a_ok_in    = 1'b0;
               end
            end else begin
               lo_in    = hi_ff;
               state_in = ST_MERGE;
            end
         end
         ST_PICK_RD: begin
            case (pick_ff)
               PICK_MIN:    rd_addr = '0;
               PICK_LOWER:  rd_addr = AW'(n_w >> 2);
               PICK_MEDIAN: rd_addr = AW'(n_w >> 1);
               PICK_UPPER:  rd_addr = AW'(n3 >> 2);
               default:     rd_addr = AW'(count_ff - 1'b1);
            endcase
            state_in = ST_PICK_CAP;
         end
         ST_PICK_CAP: begin
            case (pick_ff)
               PICK_MIN:    res_in.minimum        = rd_data;
               PICK_LOWER:  res_in.lower_quartile = rd_data;
               PICK_MEDIAN: res_in.median         = rd_data;
               PICK_UPPER:  res_in.upper_quartile = rd_data;
               default:     res_in.maximum        = rd_data;
            endcase
            if (pick_ff == PICK_MAX) begin
               div_start = 1'b1;
               state_in  = ST_DIVIDE;
            end else begin
               pick_in  = pick_ff + 1'b1;
               state_in = ST_PICK_RD;
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               res_in.mean_fixed = quotient[MEAN_W-1:0];
               res_in.sum_total  = sum_ff;
               res_in.count      = COUNT_W'(count_ff);
               res_in.overflowed = ovf_ff;
               state_in          = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               count_in     = '0;
               sum_in       = '0;
               ovf_in       = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         sum_ff       <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      width_ff    <= width_in;
      lo_ff       <= lo_in;
      mid_ff      <= mid_in;
      hi_ff       <= hi_in;
      i_ff        <= i_in;
      j_ff        <= j_in;
      k_ff        <= k_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      a_ok_ff     <= a_ok_in;
      b_ok_ff     <= b_ok_in;
      src_ff      <= src_in;
      tgt_ff      <= tgt_in;
      pick_ff     <= pick_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign rd_data   = src_ff ? rd1 : rd0;

   qsu_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (MAX_VALUES)
   ) u_ram0 (
      .clock   (clock),
      .wr_en   (load_we || (sort_we && src_ff)),
      .wr_addr (load_we ? count_ff[AW-1:0] : k_ff[AW-1:0]),
      .wr_data (load_we ? req_data.sample : sort_wdata),
      .rd_addr (rd_addr),
      .rd_data (rd0)
   );

   qsu_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (MAX_VALUES)
   ) u_ram1 (
      .clock   (clock),
      .wr_en   (sort_we && !src_ff),
      .wr_addr (k_ff[AW-1:0]),
      .wr_data (sort_wdata),
      .rd_addr (rd_addr),
      .rd_data (rd1)
   );

   qsu_divider #(
      .DIVISOR_W (CW)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({sum_ff, FRAC_W'(0)}),
      .divisor  (count_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   `QSU_ASSERT_IMPLY(a_emit_in_run, clock, reset,
      state_ff == ST_EMIT && (a_ok_ff || b_ok_ff), k_ff < hi_ff)
   `QSU_ASSERT_IMPLY(a_div_done_state, clock, reset, div_done, state_ff == ST_DIVIDE)
   `QSU_ASSERT_IMPLY(a_count_cap, clock, reset, 1'b1, count_ff <= CW'(MAX_VALUES))

endmodule

/* tb/sv/quartile_summary_unsigned_core_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quartile_summary_unsigned_core_test
// self-checking bench for the quartile summary core: a directed table of
// sets, then random sets of mostly small sizes plus one set past capacity,
// with request gaps and response stalls; each closing transaction is summarized
// by an in-bench sorter or a typed table row; responses are checked in order
// ----------------------------------------------------------------------------
module quartile_summary_unsigned_core_test;
   import qsu_pkg::*;

   localparam int CAPACITY    = 1024;
   localparam int CYCLE_LIMIT = 2000000;

   typedef struct {
      req_type item;
      bit      typed;
      rsp_type summary;
   } row_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   logic [SAMPLE_W-1:0] set_values[$];
   logic [SUM_W-1:0]    set_sum;
   bit                  set_dropped;
   rsp_type             pending_summaries[$];
   int                  gap_pct;
   int                  stall_pct;
   int                  mismatches = 0;
   int                  cycles = 0;
   row_type             directed[$];

   quartile_summary_unsigned_core #(.MAX_VALUES(CAPACITY)) DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // update the set model with one accepted transaction; on a closing one, give its summary and return 1
   function automatic bit summarize(input req_type t, output rsp_type s);
      logic [SAMPLE_W-1:0] sorted[$];
      int                  n;
      s = '0;
      if (t.has_sample) begin
         if (set_values.size() < CAPACITY) begin
            set_values.push_back(t.sample);
            set_sum = set_sum + t.sample;
         end else begin
            set_dropped = 1'b1;
         end
      end
      if (!t.last) return 1'b0;
      n = set_values.size();
      if (n > 0) begin
         sorted = set_values;
         sorted.sort();
         s.minimum        = sorted[0];
         s.lower_quartile = sorted[n / 4];
         s.median         = sorted[n / 2];
         s.upper_quartile = sorted[(3 * n) / 4];
         s.maximum        = sorted[n - 1];
         s.sum_total      = set_sum;
         s.mean_fixed     = MEAN_W'(({8'd0, set_sum} << FRAC_W) / n);
         s.count          = COUNT_W'(n);
      end
      s.overflowed = set_dropped;
      set_values.delete();
      set_sum     = '0;
      set_dropped = 1'b0;
      return 1'b1;
   endfunction

   task automatic send(input req_type t, input bit typed, input rsp_type typed_summary);
      rsp_type s;
      while ($urandom_range(99) < gap_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = t;
      do @(posedge clock); while (req_stall);
      if (summarize(t, s)) pending_summaries.push_back(typed ? typed_summary : s);
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic send_sample(input logic [SAMPLE_W-1:0] v, input bit has, input bit cl);
      req_type t;
      t.sample     = v;
      t.has_sample = has;
      t.last       = cl;
      send(t, 1'b0, '0);
   endtask

   function automatic logic [SAMPLE_W-1:0] random_sample();
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         2: return SAMPLE_W'($urandom_range(15));
         default: return $urandom();
      endcase
   endfunction

   task automatic add_row(input logic [SAMPLE_W-1:0] v, input bit has, input bit cl,
                          input bit typed = 1'b0, input rsp_type s = '0);
      row_type r;
      r.item.sample     = v;
      r.item.has_sample = has;
      r.item.last       = cl;
      r.typed           = typed;
      r.summary         = s;
      directed.push_back(r);
   endtask

   // response checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_summaries.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %h", rsp_data);
         end else begin
            rsp_type e;
            e = pending_summaries.pop_front();
            if (rsp_data.minimum !== e.minimum || rsp_data.lower_quartile !== e.lower_quartile
                || rsp_data.median !== e.median || rsp_data.upper_quartile !== e.upper_quartile
                || rsp_data.maximum !== e.maximum || rsp_data.sum_total !== e.sum_total
                || rsp_data.mean_fixed !== e.mean_fixed || rsp_data.count !== e.count
                || rsp_data.overflowed !== e.overflowed) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %p actual %p", e, rsp_data);
            end
         end
      end
   end

   always @(negedge clock) rsp_stall <= ($urandom_range(99) < stall_pct);

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("** quartile_summary_unsigned_core: FAILED **");
         $finish;
      end
   end

   initial begin
      rsp_type s;
      int      phase;
      int      sent;
      int      n;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      gap_pct     = 0;
      stall_pct   = 0;
      set_sum     = '0;
      set_dropped = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // empty set right after reset
      add_row('0, 1'b0, 1'b1, 1'b1, '0);
      add_row('1, 1'b0, 1'b0);
      // single largest value closing its own set
      s = '{minimum: '1, lower_quartile: '1, median: '1, upper_quartile: '1, maximum: '1,
            sum_total: 42'hFFFFFFFF, mean_fixed: 40'hFFFFFFFF00, count: 11'd1,
            overflowed: 1'b0};
      add_row('1, 1'b1, 1'b1, 1'b1, s);
      s = '0;
      s.count = 11'd1;
      add_row('0, 1'b1, 1'b1, 1'b1, s);
      add_row(32'h0000_0005, 1'b1, 1'b0);
      add_row('1, 1'b1, 1'b0);
      add_row(32'h5555_5555, 1'b0, 1'b0);
      add_row('0, 1'b1, 1'b0);
      add_row(32'h0000_0005, 1'b1, 1'b0);
      add_row(32'hAAAA_AAAA, 1'b0, 1'b1);
      add_row(32'h8000_0000, 1'b1, 1'b0);
      add_row(32'h7FFF_FFFF, 1'b1, 1'b0);
      add_row(32'h0000_0001, 1'b1, 1'b0);
      add_row('0, 1'b0, 1'b0);
      add_row(32'hFFFF_FFFE, 1'b1, 1'b0);
      add_row(32'h1234_5678, 1'b1, 1'b0);
      add_row(32'h0000_0003, 1'b1, 1'b0);
      add_row(32'hDEAD_BEEF, 1'b1, 1'b1);
      add_row('1, 1'b1, 1'b0);
      add_row('1, 1'b1, 1'b1);
      foreach (directed[i]) send(directed[i].item, directed[i].typed, directed[i].summary);

      // hold off until the directed responses are all back
      while (pending_summaries.size() != 0) @(negedge clock);

      sent = 0;
      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 51; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 51; end
            default: begin gap_pct = 10; stall_pct = 10; end
         endcase
         if (phase == 2) begin
            // one set past capacity
            for (int k = 0; k < CAPACITY + 6; k++) send_sample(random_sample(), 1'b1, 1'b0);
            send_sample(random_sample(), $urandom_range(1), 1'b1);
            sent += CAPACITY + 7;
         end
         while (sent < 80 * (phase + 1) + (phase >= 2 ? CAPACITY + 7 : 0)) begin
            if ($urandom_range(9) == 0) begin
               send_sample($urandom(), $urandom_range(1), $urandom_range(1));
               sent++;
            end else begin
               n = $urandom_range(12);
               for (int k = 0; k < n; k++) begin
                  if ($urandom_range(9) == 0) send_sample($urandom(), 1'b0, 1'b0);
                  send_sample(random_sample(), 1'b1, 1'b0);
               end
               if (n > 0 && $urandom_range(1)) send_sample(random_sample(), 1'b1, 1'b1);
               else send_sample($urandom(), 1'b0, 1'b1);
               sent += n + 1;
            end
         end
      end

      while (pending_summaries.size() != 0) @(negedge clock);
      repeat (100) @(negedge clock);
      if (mismatches == 0 && pending_summaries.size() == 0) begin
         $display("** quartile_summary_unsigned_core: PASSED **");
      end else begin
         $display("** quartile_summary_unsigned_core: FAILED **");
      end
      $finish;
   end

endmodule
